/* rtl/spid_pkg.sv */
// Package: shared constants for the servo position PID block.
package spid_pkg;
  localparam int FAULT_LIMIT_DEF = 100;
  localparam int ANGLE_BITS_DEF  = 14;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 24;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPAN        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_P_GAIN      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_I_GAIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_D_GAIN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_D_SMOOTH    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_MODE  = 3'd7;
endpackage

/* rtl/servo_position_pid_with_encoder_check_top.sv */
// Top level: servo position PID with encoder frame check, sequenced datapath.
//
// Usage:
//  - in_ channel carries one control tick per transaction:
//    in_tdata = {clear_fault, loop_active, target_position[16:0], encoder_frame[15:0]}.
//  - out_ channel returns one result transaction per tick:
//    out_tdata = {bad_frame_count, frame_good, measured_position, drive_valid,
//    drive_value}.
//  - cfg_ port writes one of eight registers; the user must write only while the block is idle (not enforced).
// The derivative division is skipped when the error is unchanged. The sequence is
// governed by the shared restoring divider (52 quotient bits, one per cycle, used
// for the position and the derivative) and one shared multiplier that forms five
// products. in_tready is low from acceptance until the result has been taken, so
// a new tick is not accepted before the last result has left the block.
// Reset (rst_n low, synchronous) clears all loop state and loads register
// defaults. When the receiver stalls, the result holds in the output register
// and no new tick is accepted.
module servo_position_pid_with_encoder_check_top
  import spid_pkg::*;
#(
  parameter int FAULT_LIMIT = FAULT_LIMIT_DEF,
  parameter int ANGLE_BITS  = ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] encoder_frame, [32:16] target_position, [33] loop_active,
  // [34] clear_fault, [39:35] zero
  input  logic [39:0]           in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [15:0] drive_value, [16] drive_valid, [34:17] measured_position,
  // [35] frame_good, [43:36] bad_frame_count, [47:44] zero
  output logic [47:0]           out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);
  localparam int FULL = 1 << ANGLE_BITS;
  // wrap when diff * 360 drops below -20 degrees worth of counts
  localparam logic signed [31:0] WRAP_LIM = 32'(-20 * FULL);
  // ceil(2^34 / 100); (u * RECIP_100) >> 34 equals floor(u / 100) for u < 2^30
  localparam logic [27:0] RECIP_100   = 28'd171798692;
  localparam int          RECIP_SHIFT = 34;
  localparam logic [5:0]  DIV_STEPS   = 6'd52;
  localparam logic signed [17:0] MEAS_MAX = 18'sd131071;
  localparam logic signed [17:0] MEAS_MIN = -MEAS_MAX - 18'sd1;

  typedef enum logic [3:0] {
    S_IDLE, S_POS, S_DIV1, S_MEAS, S_MULP, S_MULI, S_RECIP, S_MULD, S_DIV2,
    S_MULF, S_SUM, S_OUT, S_HOLD
  } state_t;

  // config
  logic [13:0] zero_r, span_r;
  logic [23:0] pg_r, ig_r, dg_r;
  logic [16:0] ds_r;
  logic [15:0] db_r;
  logic [1:0]  mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_r <= '0; span_r <= 14'h3FFF; pg_r <= '0; ig_r <= '0; dg_r <= '0;
      ds_r <= 17'd65536; db_r <= '0; mode_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ZERO_OFFSET: zero_r <= cfg_wdata[13:0];
        REG_SPAN:        span_r <= cfg_wdata[13:0];
        REG_P_GAIN:      pg_r   <= cfg_wdata;
        REG_I_GAIN:      ig_r   <= cfg_wdata;
        REG_D_GAIN:      dg_r   <= cfg_wdata;
        REG_D_SMOOTH:    ds_r   <= cfg_wdata[16:0];
        REG_DEAD_BAND:   db_r   <= cfg_wdata[15:0];
        REG_DRIVE_MODE:  mode_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // loop state
  state_t      state_r;
  logic [15:0] held_r;
  logic signed [17:0] integ_r;
  logic signed [18:0] lerr_r;
  logic signed [23:0] filt_r;
  logic [15:0] ticks_r;
  logic [7:0]  fault_r;
  // per-tick registers
  logic [16:0] tgt_r;
  logic        act_r, good_r;
  logic signed [17:0] meas_r;
  logic signed [18:0] err_r;
  logic signed [17:0] p_r;
  logic signed [26:0] de100_r;
  logic        ineg_r;
  logic [26:0] u_r;
  logic signed [23:0] draw_r;
  logic signed [17:0] o_r;
  // shared divider: unsigned restoring, 52-bit dividend, 32-bit divisor
  logic [51:0] dq_r;
  logic [31:0] drem_r, dvs_r;
  logic [5:0]  dcnt_r;
  logic        dneg_r;
  logic [47:0] out_r;

  // shared 29 x 33 signed multiplier (one product per cycle)
  logic signed [28:0] ma;
  logic signed [32:0] mb;
  logic signed [61:0] mprod, mshift;
  assign mprod  = ma * mb;
  assign mshift = mprod >>> 16;

  // divider step
  logic [32:0] dtrial;
  assign dtrial = {drem_r, dq_r[51]} - {1'b0, dvs_r};

  // signed quotient with floor rounding
  logic signed [52:0] q_floor;
  assign q_floor = dneg_r ? -$signed({1'b0, dq_r}) - ((drem_r != '0) ? 53'sd1 : 53'sd0)
                          : $signed({1'b0, dq_r});

  // frame check and fault count
  logic [15:0] frame;
  logic        fgood;
  logic [7:0]  fault_clr, fault_upd;
  logic [16:0] tgt_in;
  assign frame     = in_tdata[15:0];
  assign fgood     = ~(^frame) && (frame != 16'hFFFF);
  assign fault_clr = in_tdata[34] ? 8'd0 : fault_r;
  assign fault_upd = fgood ? 8'd0
                   : ((fault_clr != 8'd255) ? fault_clr + 8'd1 : fault_clr);
  assign tgt_in    = (in_tdata[32:16] > 17'd65536) ? 17'd65536 : in_tdata[32:16];

  // position
  logic signed [31:0] diff_raw, diff_w;
  logic [31:0] diff_mag;
  assign diff_raw = $signed({16'd0, held_r}) - $signed({18'd0, zero_r});
  assign diff_w   = (diff_raw * 32'sd360 < WRAP_LIM) ? diff_raw + 32'(FULL) : diff_raw;
  assign diff_mag = diff_w[31] ? 32'(-diff_w) : 32'(diff_w);

  logic signed [17:0] meas_sat;
  logic signed [18:0] err_nxt;
  assign meas_sat = (q_floor > 53'(MEAS_MAX)) ? MEAS_MAX
                  : ((q_floor < 53'(MEAS_MIN)) ? MEAS_MIN : 18'(q_floor));
  assign err_nxt  = $signed({2'b0, tgt_r}) - 19'(meas_sat);

  // proportional term and error delta
  logic signed [17:0] p_sat;
  logic signed [19:0] de;
  logic signed [26:0] de100;
  assign p_sat = (mshift > 62'sd65536) ? 18'sd65536
               : ((mshift < -62'sd65536) ? -18'sd65536 : 18'(mshift));
  assign de    = 20'(err_r) - 20'(lerr_r);
  assign de100 = 27'(de) * 27'sd100;

  // integral: floor(x / 6553600) as floor(floor(x / 65536) / 100)
  logic [26:0] u_nxt;
  logic signed [31:0] q100, inc_v, isum, pabs, ilim;
  logic signed [17:0] integ_nxt;
  assign u_nxt     = mshift[61] ? 27'(62'sd99 - mshift) : 27'(mshift);
  assign q100      = 32'(mprod >>> RECIP_SHIFT);
  assign inc_v     = ineg_r ? -q100 : q100;
  assign isum      = (act_r ? 32'(integ_r) : 32'sd0) + inc_v;
  assign pabs      = p_r[17] ? -32'(p_r) : 32'(p_r);
  assign ilim      = 32'sd65536 - pabs;
  assign integ_nxt = (isum > ilim) ? 18'(ilim) : ((isum < -ilim) ? 18'(-ilim) : 18'(isum));

  // derivative
  logic [15:0] ticks_inc;
  logic signed [23:0] draw_sat;
  logic [16:0] cv;
  logic signed [24:0] fdiff;
  logic signed [61:0] fsum;
  assign ticks_inc = (ticks_r != 16'hFFFF) ? ticks_r + 16'd1 : ticks_r;
  assign draw_sat  = (q_floor > 53'sd8388607) ? 24'sd8388607
                   : ((q_floor < -53'sd8388607) ? -24'sd8388607 : 24'(q_floor));
  assign cv        = (ds_r > 17'd65536) ? 17'd65536 : ds_r;
  assign fdiff     = 25'(draw_r) - 25'(filt_r);
  assign fsum      = 62'(filt_r) + mshift;

  // output sum with deadband
  logic signed [17:0] db2, o_sat;
  logic signed [25:0] o_raw, o_db;
  assign db2   = (db_r > 16'd32768) ? 18'sd65536 : $signed({1'b0, db_r, 1'b0});
  assign o_raw = 26'(p_r) + 26'(integ_r) + 26'(filt_r);
  assign o_db  = o_raw[25] ? o_raw - 26'(db2) : o_raw + 26'(db2);
  assign o_sat = (o_db > 26'sd65536) ? 18'sd65536
               : ((o_db < -26'sd65536) ? -18'sd65536 : 18'(o_db));

  // drive mapping
  logic signed [18:0] s_v, half;
  logic signed [20:0] s3, vt;
  logic [15:0] duty_d, vduty, duty;
  logic        fault_ok, dvalid;
  assign s_v      = mode_r[0] ? 19'(o_r) : -19'(o_r);
  assign half     = s_v >>> 1;
  assign duty_d   = (half > 19'sd32767) ? 16'd32767 : 16'(half);
  assign s3       = 21'(s_v) * 21'sd3;
  assign vt       = (s3 >>> 2) + 21'sd65536;
  assign vduty    = 16'(vt >>> 2);
  assign fault_ok = fault_r < 8'(FAULT_LIMIT);

  always_comb begin
    if (!mode_r[1]) begin
      dvalid = fault_ok;
      duty   = fault_ok ? duty_d : 16'd0;
    end else begin
      dvalid = 1'b1;
      duty   = fault_ok ? vduty : 16'd16384;
    end
  end

  // multiplier operand select
  always_comb begin
    ma = '0; mb = '0;
    unique case (state_r)
      S_MULP:  begin ma = 29'(err_r); mb = $signed({9'd0, pg_r}); end
      S_MULI:  begin ma = 29'(err_r); mb = $signed({9'd0, ig_r}); end
      S_RECIP: begin ma = $signed({1'b0, RECIP_100}); mb = $signed({6'd0, u_r}); end
      S_MULD:  begin ma = 29'(de100_r); mb = $signed({9'd0, dg_r}); end
      S_MULF:  begin ma = $signed({12'd0, cv}); mb = 33'(fdiff); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; held_r <= '0; integ_r <= '0; lerr_r <= '0; filt_r <= '0;
      ticks_r <= '0; fault_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          tgt_r <= tgt_in;
          act_r <= in_tdata[33];
          good_r <= fgood;
          if (fgood) held_r <= frame & 16'(FULL - 1);
          fault_r <= fault_upd;
          state_r <= S_POS;
        end
        S_POS: begin
          dneg_r <= diff_w[31];
          dq_r <= 52'(diff_mag) << 16;
          drem_r <= '0;
          dvs_r <= (span_r == '0) ? 32'd1 : 32'(span_r);
          dcnt_r <= DIV_STEPS;
          state_r <= S_DIV1;
        end
        S_DIV1, S_DIV2: begin
          if (dcnt_r != '0) begin
            if (!dtrial[32]) begin
              drem_r <= dtrial[31:0]; dq_r <= {dq_r[50:0], 1'b1};
            end else begin
              drem_r <= {drem_r[30:0], dq_r[51]}; dq_r <= {dq_r[50:0], 1'b0};
            end
            dcnt_r <= dcnt_r - 6'd1;
          end else if (state_r == S_DIV1) begin
            state_r <= S_MEAS;
          end else begin
            draw_r <= draw_sat;
            state_r <= S_MULF;
          end
        end
        S_MEAS: begin
          meas_r <= meas_sat;
          err_r <= err_nxt;
          state_r <= S_MULP;
        end
        S_MULP: begin
          p_r <= p_sat;
          de100_r <= de100;
          state_r <= S_MULI;
        end
        S_MULI: begin
          ineg_r <= mshift[61];
          u_r <= u_nxt;
          state_r <= S_RECIP;
        end
        S_RECIP: begin
          integ_r <= integ_nxt;
          state_r <= S_MULD;
        end
        S_MULD: begin
          if (err_r == lerr_r) begin
            draw_r <= '0;
            ticks_r <= ticks_inc;
            state_r <= S_MULF;
          end else begin
            dneg_r <= mprod[61];
            dq_r <= 52'(mprod[61] ? -mprod : mprod);
            drem_r <= '0;
            dvs_r <= {ticks_inc, 16'd0};
            dcnt_r <= DIV_STEPS;
            ticks_r <= '0;
            state_r <= S_DIV2;
          end
        end
        S_MULF: begin
          filt_r <= 24'(fsum);
          lerr_r <= err_r;
          state_r <= S_SUM;
        end
        S_SUM: begin
          o_r <= o_sat;
          state_r <= S_OUT;
        end
        S_OUT: begin
          out_r <= {4'd0, fault_r, good_r, meas_r, dvalid, duty};
          state_r <= S_HOLD;
        end
        S_HOLD: if (out_tready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_HOLD);
  assign out_tdata  = out_r;

`ifndef ASSERT_OFF
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid))
    else $error("ready during result hold");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_integ: assert property (@(posedge clk) disable iff (!rst_n)
    integ_r <= 18'sd65536 && integ_r >= -18'sd65536)
    else $error("integrator out of range");
`endif
endmodule
